[src/thv_pkg.sv]
// Package for the tar header validator: word types, codes and magic tables.
`timescale 1ns / 1ps
package thv_pkg;

    // Header geometry and checksum constants.
    localparam int HdrLen      = 512;
    localparam int PosW        = 10;
    localparam int SumW        = 17;
    localparam int SumInit     = 256;
    localparam int NameEnd     = 100;
    localparam int ModeEnd     = 108;
    localparam int MtimeStart  = 136;
    localparam int MtimeEnd    = 148;
    localparam int CksumStart  = 148;
    localparam int CksumEnd    = 156;
    localparam int MagicStart  = 257;
    localparam int PosixLen    = 6;
    localparam int GnuLen      = 8;

    // Format codes of the result word.
    localparam logic [1:0] FMT_V7    = 2'd0;
    localparam logic [1:0] FMT_GNU   = 2'd1;
    localparam logic [1:0] FMT_POSIX = 2'd2;

    // Octal reader phases.
    localparam logic [1:0] OCT_SKIP   = 2'd0;
    localparam logic [1:0] OCT_SIGN   = 2'd1;
    localparam logic [1:0] OCT_DIGITS = 2'd2;
    localparam logic [1:0] OCT_DONE   = 2'd3;

    // Magic candidate bits.
    localparam int CandPosix = 0;
    localparam int CandGnu   = 1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } hdr_word_t;

    typedef struct packed {
        logic            is_tar;
        logic [1:0]      format;
        logic [SumW-1:0] header_sum;
    } res_word_t;

    // Expected POSIX magic byte: "ustar" then NUL.
    function automatic logic [7:0] posix_magic(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected old GNU magic byte: "ustar", two spaces, then NUL.
    function automatic logic [7:0] gnu_magic(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            3'd5:    c = 8'h20;
            3'd6:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[src/thv_hdr_if.sv]
// Stream interface that carries header bytes into the validator.
`timescale 1ns / 1ps
interface thv_hdr_if
    import thv_pkg::*;
();
    logic      valid;
    logic      ready;
    hdr_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/thv_res_if.sv]
// Stream interface that carries validation results out of the validator.
`timescale 1ns / 1ps
interface thv_res_if
    import thv_pkg::*;
();
    logic      valid;
    logic      ready;
    res_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/tar_header_validator_unit.sv]
// Top level of the tar header validator: per-byte checks, checksum and octal parse.
//
//  channel  dir  word                                   accepted when
//  hdr      in   data_byte[7:0], last_byte              hdr.valid && hdr.ready
//  res      out  is_tar, format[1:0], header_sum[16:0]  res.valid && res.ready
//
// One byte is taken each cycle while hdr.ready is high; all checks for it settle
// in combinational logic between the state registers and the result register.
// A result is registered when byte 511, or a byte with last_byte set, is taken.
// The result register is backed by a one-word skid stage, so bytes keep flowing
// while a result waits; hdr.ready drops only while the skid stage is full.
// Reset (rst_n low, asynchronous) clears the position, the checks and both stages.
`timescale 1ns / 1ps
module tar_header_validator_unit
    import thv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    thv_hdr_if.sink   hdr,
    thv_res_if.source res
);

    // Running header state.
    logic [PosW-1:0] pos_reg;
    logic [SumW-1:0] sum_reg;
    logic            reject_reg;
    logic            name_ended_reg;
    logic            mtime_ended_reg;
    logic [1:0]      magic_reg;
    logic [1:0]      oct_phase_reg;
    logic            oct_neg_reg;
    logic [SumW-1:0] oct_val_reg;
    logic            oct_ovf_reg;

    // Output and skid stages.
    logic      out_valid_reg;
    res_word_t out_word_reg;
    logic      skid_valid_reg;
    res_word_t skid_word_reg;

    logic [7:0]      b;
    logic            accept;
    logic            done;
    logic            push;
    logic            is_oct;
    logic            is_ws;
    logic [SumW+2:0] shifted;
    logic [2:0]      magic_k;
    logic            reject_next;
    logic            name_ended_next;
    logic            mtime_ended_next;
    logic [1:0]      magic_next;
    logic [SumW-1:0] sum_next;
    logic [1:0]      oct_phase_next;
    logic            oct_neg_next;
    logic [SumW-1:0] oct_val_next;
    logic            oct_ovf_next;
    res_word_t       res_next;

    assign b       = hdr.data.data_byte;
    assign hdr.ready = !skid_valid_reg;
    assign accept  = hdr.valid && hdr.ready;
    assign done    = pos_reg >= PosW'(HdrLen - 1);
    assign push    = accept && (done || hdr.data.last_byte);
    assign is_oct  = b inside {[8'h30:8'h37]};
    assign is_ws   = b inside {8'h20, [8'h09:8'h0D]};
    assign shifted = {oct_val_reg, 3'b000} + {{SumW{1'b0}}, b[2:0]};
    assign magic_k = 3'(pos_reg - PosW'(MagicStart));

    // Field checks, magic match, checksum and octal reader for this byte.
    always_comb
    begin
        reject_next      = reject_reg;
        name_ended_next  = name_ended_reg;
        mtime_ended_next = mtime_ended_reg;
        magic_next       = magic_reg;
        sum_next         = sum_reg;
        oct_phase_next   = oct_phase_reg;
        oct_neg_next     = oct_neg_reg;
        oct_val_next     = oct_val_reg;
        oct_ovf_next     = oct_ovf_reg;

        // Name, mode and mtime fields; bytes of 0x80 and up are rejected.
        if (pos_reg < PosW'(NameEnd))
        begin
            if (!name_ended_reg)
            begin
                if (b == 8'h00)
                    name_ended_next = 1'b1;
                else if (b < 8'h20 || b[7])
                    reject_next = 1'b1;
            end
        end
        else if (pos_reg < PosW'(ModeEnd))
        begin
            if (!(is_oct || b == 8'h00 || b == 8'h20))
                reject_next = 1'b1;
        end
        else if (pos_reg >= PosW'(MtimeStart) && pos_reg < PosW'(MtimeEnd))
        begin
            if (!mtime_ended_reg)
            begin
                if (b == 8'h00)
                    mtime_ended_next = 1'b1;
                else if (b < 8'h20 || b[7])
                    reject_next = 1'b1;
            end
        end

        // Magic comparison against both candidate strings.
        if (pos_reg >= PosW'(MagicStart) && pos_reg < PosW'(MagicStart + GnuLen))
        begin
            if (magic_k < 3'(PosixLen) && b != posix_magic(magic_k))
                magic_next[CandPosix] = 1'b0;
            if (b != gnu_magic(magic_k))
                magic_next[CandGnu] = 1'b0;
        end

        // Byte sum, skipping the checksum field itself.
        if (pos_reg < PosW'(CksumStart) || pos_reg >= PosW'(CksumEnd))
            sum_next = sum_reg + SumW'(b);

        // Octal reader from the checksum field onward.
        if (pos_reg >= PosW'(CksumStart))
        begin
            case (oct_phase_reg)
                OCT_SKIP:
                begin
                    if (is_ws)
                        oct_phase_next = OCT_SKIP;
                    else if (b == 8'h2B || b == 8'h2D)
                    begin
                        oct_neg_next   = (b == 8'h2D);
                        oct_phase_next = OCT_SIGN;
                    end
                    else if (is_oct)
                    begin
                        oct_val_next   = shifted[SumW-1:0];
                        oct_ovf_next   = oct_ovf_reg || (|shifted[SumW+2:SumW]);
                        oct_phase_next = OCT_DIGITS;
                    end
                    else
                        oct_phase_next = OCT_DONE;
                end
                OCT_SIGN, OCT_DIGITS:
                begin
                    if (is_oct)
                    begin
                        oct_val_next   = shifted[SumW-1:0];
                        oct_ovf_next   = oct_ovf_reg || (|shifted[SumW+2:SumW]);
                        oct_phase_next = OCT_DIGITS;
                    end
                    else
                        oct_phase_next = OCT_DONE;
                end
                default:
                    oct_phase_next = OCT_DONE;
            endcase
        end

        // Result word for a full or a short header.
        if (done)
        begin
            res_next.is_tar = !reject_next && !oct_ovf_next && !oct_neg_next &&
                              (oct_val_next == sum_next);
            if (magic_next[CandPosix])
                res_next.format = FMT_POSIX;
            else if (magic_next[CandGnu])
                res_next.format = FMT_GNU;
            else
                res_next.format = FMT_V7;
            res_next.header_sum = sum_next;
        end
        else
        begin
            res_next.is_tar     = 1'b0;
            res_next.format     = FMT_V7;
            res_next.header_sum = '0;
        end
    end

    // Running state update; a finished or short header returns it to reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            sum_reg         <= SumW'(SumInit);
            reject_reg      <= 1'b0;
            name_ended_reg  <= 1'b0;
            mtime_ended_reg <= 1'b0;
            magic_reg       <= 2'b11;
            oct_phase_reg   <= OCT_SKIP;
            oct_neg_reg     <= 1'b0;
            oct_val_reg     <= '0;
            oct_ovf_reg     <= 1'b0;
        end
        else if (push)
        begin
            pos_reg         <= '0;
            sum_reg         <= SumW'(SumInit);
            reject_reg      <= 1'b0;
            name_ended_reg  <= 1'b0;
            mtime_ended_reg <= 1'b0;
            magic_reg       <= 2'b11;
            oct_phase_reg   <= OCT_SKIP;
            oct_neg_reg     <= 1'b0;
            oct_val_reg     <= '0;
            oct_ovf_reg     <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg         <= pos_reg + PosW'(1);
            sum_reg         <= sum_next;
            reject_reg      <= reject_next;
            name_ended_reg  <= name_ended_next;
            mtime_ended_reg <= mtime_ended_next;
            magic_reg       <= magic_next;
            oct_phase_reg   <= oct_phase_next;
            oct_neg_reg     <= oct_neg_next;
            oct_val_reg     <= oct_val_next;
            oct_ovf_reg     <= oct_ovf_next;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !res.ready)
        begin
            if (push)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
            out_valid_reg <= push;
    end

    // Payload of the output and skid stages.
    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !res.ready)
        begin
            if (push)
                skid_word_reg <= res_next;
        end
        else if (skid_valid_reg)
            out_word_reg <= skid_word_reg;
        else if (push)
            out_word_reg <= res_next;
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_word_reg;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the tar header validator: builder, driver and scoreboard.
`timescale 1ns / 1ps
module testbench
    import thv_pkg::*;
();

    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 16;
    localparam int ITEM_WORDS   = 950;

    // Magic tags as byte strings, first byte in the top bits.
    localparam logic [47:0] POSIX_TAG = {"ustar", 8'h00};
    localparam logic [63:0] GNU_TAG   = {"ustar  ", 8'h00};

    // Ways of filling the checksum field of a generated header.
    typedef enum int {
        CK_PLAIN,
        CK_LEAD_WS,
        CK_PLUS,
        CK_MINUS,
        CK_SIGN_ONLY,
        CK_OVERFLOW,
        CK_RUN_ON,
        CK_GARBAGE
    } cksum_style_e;

    // Predicts the verdict of each header and checks the words that come out.
    class tar_verdict_model;
        int          pos;
        logic [16:0] sum;
        bit          rejected;
        bit          name_done;
        bit          mtime_done;
        logic [1:0]  cand;
        logic [1:0]  oct_phase;
        bit          oct_neg;
        logic [16:0] oct_val;
        bit          oct_ovf;
        res_word_t   verdicts_due[$];
        int          fails;

        function new();
            fails = 0;
            clear_state();
        endfunction

        function void clear_state();
            pos = 0;
            sum = 17'(SumInit);
            rejected = 1'b0;
            name_done = 1'b0;
            mtime_done = 1'b0;
            cand = 2'b11;
            oct_phase = OCT_SKIP;
            oct_neg = 1'b0;
            oct_val = '0;
            oct_ovf = 1'b0;
        endfunction

        function bit is_octal_digit(logic [7:0] b);
            return b >= "0" && b <= "7";
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
        endfunction

        function void shift_digit(logic [7:0] b);
            int nxt;
            nxt = (int'(oct_val) << 3) + int'(b) - 48;
            if (nxt > 32'h1FFFF)
                oct_ovf = 1'b1;
            oct_val = nxt[16:0];
            oct_phase = OCT_DIGITS;
        endfunction

        // strtoll-style reader: blanks, optional sign, then octal digits.
        function void feed_octal(logic [7:0] b);
            case (oct_phase)
                OCT_SKIP:
                begin
                    if (is_blank(b))
                    begin
                    end
                    else if (b == "+" || b == "-")
                    begin
                        oct_neg = (b == "-");
                        oct_phase = OCT_SIGN;
                    end
                    else if (is_octal_digit(b))
                        shift_digit(b);
                    else
                        oct_phase = OCT_DONE;
                end
                OCT_SIGN, OCT_DIGITS:
                begin
                    if (is_octal_digit(b))
                        shift_digit(b);
                    else
                        oct_phase = OCT_DONE;
                end
                default:
                begin
                end
            endcase
        endfunction

        // Notes one accepted byte and queues the verdict it causes, if any.
        function void take_byte(hdr_word_t w);
            logic [7:0] b;
            res_word_t  r;
            int         k;
            b = w.data_byte;

            // Field checks on name, mode and mtime.
            if (pos < NameEnd)
            begin
                if (!name_done)
                begin
                    if (b == 8'h00)
                        name_done = 1'b1;
                    else if (b < 8'h20 || b >= 8'h80)
                        rejected = 1'b1;
                end
            end
            else if (pos < ModeEnd)
            begin
                if (!(is_octal_digit(b) || b == 8'h00 || b == " "))
                    rejected = 1'b1;
            end
            else if (pos >= MtimeStart && pos < MtimeEnd)
            begin
                if (!mtime_done)
                begin
                    if (b == 8'h00)
                        mtime_done = 1'b1;
                    else if (b < 8'h20 || b >= 8'h80)
                        rejected = 1'b1;
                end
            end

            // Magic classification.
            if (pos >= MagicStart && pos < MagicStart + GnuLen)
            begin
                k = pos - MagicStart;
                if (k < PosixLen && b != POSIX_TAG[8*(PosixLen-1-k) +: 8])
                    cand[CandPosix] = 1'b0;
                if (b != GNU_TAG[8*(GnuLen-1-k) +: 8])
                    cand[CandGnu] = 1'b0;
            end

            // The checksum field itself is left out of the sum.
            if (pos < CksumStart || pos >= CksumEnd)
                sum = sum + b;
            if (pos >= CksumStart)
                feed_octal(b);

            if (pos == HdrLen - 1)
            begin
                r.is_tar = !rejected && !oct_ovf && !oct_neg && oct_val == sum;
                r.format = cand[CandPosix] ? FMT_POSIX : (cand[CandGnu] ? FMT_GNU : FMT_V7);
                r.header_sum = sum;
                verdicts_due.push_back(r);
                clear_state();
            end
            else if (w.last_byte)
            begin
                // Short data gives an all-zero verdict.
                r = '0;
                verdicts_due.push_back(r);
                clear_state();
            end
            else
                pos++;
        endfunction

        // Compares one result word with the oldest verdict waiting.
        function void check_verdict(res_word_t r);
            res_word_t e;
            if (verdicts_due.size() == 0)
            begin
                $error("unexpected result word: is_tar %0d format %0d header_sum %0d",
                       r.is_tar, r.format, r.header_sum);
                fails++;
                return;
            end
            e = verdicts_due.pop_front();
            if (r.is_tar !== e.is_tar)
            begin
                $error("is_tar: expected %0d, got %0d", e.is_tar, r.is_tar);
                fails++;
            end
            if (r.format !== e.format)
            begin
                $error("format: expected %0d, got %0d", e.format, r.format);
                fails++;
            end
            if (r.header_sum !== e.header_sum)
            begin
                $error("header_sum: expected %0d, got %0d", e.header_sum, r.header_sum);
                fails++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    thv_hdr_if hdr_if ();
    thv_res_if res_if ();

    tar_verdict_model ledger = new();

    logic [7:0] img [HdrLen];
    int         sent = 0;
    int         cycles = 0;
    bit         src_idle = 1'b0;
    bit         sink_idle = 1'b0;
    bit         hold_req = 1'b0;
    int         stall_left = 0;

    tar_header_validator_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr_if),
        .res   (res_if)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sample both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hdr_if.valid && hdr_if.ready)
                ledger.take_byte(hdr_if.data);
            if (res_if.valid && res_if.ready)
                ledger.check_verdict(res_if.data);
        end
    end

    // Result receiver: random stall bursts and one long hold-off on request.
    initial
    begin
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                res_if.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_idle && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // Offers one word, with an occasional gap first, and waits for its acceptance.
    task automatic put_word(input logic [7:0] b, input logic l);
        hdr_word_t w;
        int        gap;
        w.data_byte = b;
        w.last_byte = l;
        if (src_idle && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 8);
            hdr_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        hdr_if.valid <= 1'b1;
        hdr_if.data <= w;
        @(posedge clk);
        while (!hdr_if.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // Holds the sender back until every verdict has been checked.
    task automatic wait_drained();
        hdr_if.valid <= 1'b0;
        @(negedge clk);
        while (ledger.verdicts_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic put_text(input int at, input string txt);
        for (int i = 0; i < txt.len(); i++)
            img[at + i] = txt[i];
    endtask

    // Builds a header image: printable name and mtime, octal mode, chosen magic,
    // and a checksum field written in the given style.
    task automatic build_header(input logic [1:0] magic, input cksum_style_e style,
                                input int name_len, input int spoil_at,
                                input logic [7:0] spoil_val);
        int nl;
        int ml;
        int s;
        int t;
        int r;
        bit found;
        for (int i = 0; i < HdrLen; i++)
            img[i] = 8'($urandom_range(0, 255));

        nl = (name_len < 0) ? $urandom_range(0, NameEnd) : name_len;
        for (int i = 0; i < nl; i++)
            img[i] = 8'($urandom_range(8'h20, 8'h7E));
        if (nl < NameEnd)
            img[nl] = 8'h00;

        for (int i = NameEnd; i < ModeEnd; i++)
        begin
            r = $urandom_range(0, 9);
            img[i] = (r < 8) ? 8'(8'h30 + r) : ((r == 8) ? 8'h00 : 8'h20);
        end

        ml = $urandom_range(0, MtimeEnd - MtimeStart);
        for (int i = 0; i < ml; i++)
            img[MtimeStart + i] = 8'($urandom_range(8'h20, 8'h7E));
        if (ml < MtimeEnd - MtimeStart)
            img[MtimeStart + ml] = 8'h00;

        // V7 gets a near miss of the old GNU tag.
        if (magic == FMT_POSIX)
        begin
            for (int k = 0; k < PosixLen; k++)
                img[MagicStart + k] = POSIX_TAG[8*(PosixLen-1-k) +: 8];
        end
        else
        begin
            for (int k = 0; k < GnuLen; k++)
                img[MagicStart + k] = GNU_TAG[8*(GnuLen-1-k) +: 8];
            if (magic == FMT_V7)
            begin
                r = $urandom_range(0, GnuLen - 1);
                img[MagicStart + r] = img[MagicStart + r] ^ 8'($urandom_range(1, 255));
            end
        end

        if (spoil_at >= 0)
            img[spoil_at] = spoil_val;

        if (style != CK_GARBAGE)
            for (int i = CksumStart; i < CksumEnd; i++)
                img[i] = 8'h20;
        if (style == CK_RUN_ON)
            img[CksumEnd + 2] = 8'h00;

        s = SumInit;
        for (int i = 0; i < HdrLen; i++)
            if (i < CksumStart || i >= CksumEnd)
                s += img[i];

        case (style)
            CK_PLAIN:
            begin
                put_text(CksumStart, $sformatf("%06o", s));
                img[CksumStart + 6] = 8'h00;
            end
            CK_LEAD_WS:
            begin
                r = $urandom_range(0, 5);
                img[CksumStart] = (r == 5) ? 8'h20 : 8'(8'h09 + r);
                put_text(CksumStart + 1, $sformatf("%06o", s));
                img[CksumStart + 7] = $urandom_range(0, 1) ? 8'h00 : 8'h20;
            end
            CK_PLUS, CK_MINUS:
            begin
                img[CksumStart] = (style == CK_PLUS) ? "+" : "-";
                put_text(CksumStart + 1, $sformatf("%06o", s));
                img[CksumStart + 7] = 8'h00;
            end
            CK_SIGN_ONLY:
                img[CksumStart] = $urandom_range(0, 1) ? "+" : "-";
            CK_OVERFLOW:
                put_text(CksumStart, "77777777");
            CK_RUN_ON:
            begin
                // Digits continue into offsets 156 and 157, which are summed too.
                s = s - img[CksumEnd] - img[CksumEnd + 1];
                found = 1'b0;
                for (int v1 = 0; v1 < 8; v1++)
                    for (int v2 = 0; v2 < 8; v2++)
                    begin
                        t = s + 96 + v1 + v2;
                        if (!found && t % 64 == v1 * 8 + v2)
                        begin
                            found = 1'b1;
                            img[CksumEnd] = 8'(8'h30 + v1);
                            img[CksumEnd + 1] = 8'(8'h30 + v2);
                            put_text(CksumStart, $sformatf("%08o", t >> 6));
                        end
                    end
                if (!found)
                    put_text(CksumStart, "00000000");
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_header(input int len, input logic end_flag);
        for (int i = 0; i < len; i++)
            put_word(img[i], (i == len - 1) ? end_flag : 1'b0);
    endtask

    task automatic send_noise(input int len);
        for (int i = 0; i < len; i++)
            put_word(8'($urandom_range(0, 255)),
                     (i == len - 1) || ($urandom_range(0, 63) == 0));
    endtask

    function automatic cksum_style_e random_style();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return CK_PLAIN;
        if (r < 11)
            return CK_LEAD_WS;
        if (r < 14)
            return CK_PLUS;
        if (r < 16)
            return CK_RUN_ON;
        if (r == 16)
            return CK_MINUS;
        if (r == 17)
            return CK_SIGN_ONLY;
        if (r == 18)
            return CK_OVERFLOW;
        return CK_GARBAGE;
    endfunction

    // Stimulus: short data, pressure, random mix, then a full header at full rate.
    initial
    begin
        int word_goal;
        int pick;
        int spoil;

        rst_n = 1'b0;
        hdr_if.valid = 1'b0;
        hdr_if.data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short data at offset zero, with both extremes of the byte.
        put_word(8'hFF, 1'b1);
        put_word(8'h00, 1'b1);

        // Long receiver hold-off while short headers keep coming, then a full pause.
        hold_req = 1'b1;
        for (int i = 0; i < 16; i++)
            send_noise($urandom_range(1, 3));
        wait_drained();

        // Random mix of cut-off headers and noise, leaving room for one full header.
        word_goal = ITEM_WORDS - HdrLen;
        while (sent < word_goal)
        begin
            src_idle = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            spoil = ($urandom_range(0, 4) == 0) ? $urandom_range(0, HdrLen - 1) : -1;
            build_header(2'($urandom_range(0, 2)), random_style(), -1, spoil,
                         8'($urandom_range(0, 255)));
            if (pick < 5)
                send_header($urandom_range(1, CksumEnd + 8), 1'b1);
            else if (pick < 9)
                send_noise($urandom_range(1, 32));
            else
                wait_drained();
        end

        // Last part runs at full rate on both sides.
        src_idle = 1'b0;
        sink_idle = 1'b0;
        build_header(FMT_POSIX, CK_PLAIN, -1, -1, 8'h00);
        send_header(HdrLen, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (ledger.fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
